@@ rtl/spn_pkg.sv @@
// Package for the substitution-permutation network block cipher.
// Holds the sizes, configuration register codes, table types and round functions.
// Used by spn_tables, spn_round and spn_block_cipher; depends on nothing else.
package spn_pkg;

  localparam int unsigned GROUP_BITS = 4;
  localparam int unsigned GROUPS     = 4;
  localparam int unsigned MAX_ROUNDS = 8;

  localparam int unsigned BLOCK_BITS = GROUPS * GROUP_BITS;
  localparam int unsigned KEY_BITS   = (GROUPS + MAX_ROUNDS) * GROUP_BITS;
  localparam int unsigned SBOX_SIZE  = 1 << GROUP_BITS;
  localparam int unsigned POS_W      = $clog2(BLOCK_BITS);
  localparam int unsigned ROUND_W    = $clog2(MAX_ROUNDS + 2);
  localparam int unsigned DATA_W     = 16;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned NIB_W      = 4;
  localparam int unsigned TABLE_W    = 64;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned ROUND_RST  = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROUND_COUNT = 2'd0,
    CFG_CIPHER_KEY  = 2'd1,
    CFG_SBOX_TABLE  = 2'd2,
    CFG_PERM_TABLE  = 2'd3
  } cfg_reg_e;

  typedef logic [BLOCK_BITS-1:0]                  block_t;
  typedef logic [SBOX_SIZE-1:0][GROUP_BITS-1:0]   sbox_t;
  typedef logic [BLOCK_BITS-1:0][POS_W-1:0]       pos_map_t;

  typedef struct packed {
    logic [ROUND_W-1:0]  rounds;
    logic [KEY_BITS-1:0] key;
    sbox_t               sbox;
    sbox_t               sbox_inv;
    pos_map_t            perm_fwd;
    pos_map_t            perm_inv;
  } spn_tables_t;

  function automatic logic [ROUND_W-1:0] clamp_rounds(logic [CNT_W-1:0] v);
    logic [ROUND_W-1:0] r;
    if (v == '0) begin
      r = ROUND_W'(1);
    end else if (int'(v) > MAX_ROUNDS) begin
      r = ROUND_W'(MAX_ROUNDS);
    end else begin
      r = ROUND_W'(v);
    end
    return r;
  endfunction

  function automatic block_t round_key(logic [KEY_BITS-1:0] key, logic [ROUND_W-1:0] i);
    logic [KEY_BITS-1:0] sh;
    sh = key >> (GROUP_BITS * (ROUND_W'(MAX_ROUNDS + 1) - i));
    return sh[BLOCK_BITS-1:0];
  endfunction

  function automatic block_t substitute(block_t x, sbox_t tbl);
    block_t y;
    for (int g = 0; g < GROUPS; g++) begin
      y[g*GROUP_BITS +: GROUP_BITS] = tbl[x[g*GROUP_BITS +: GROUP_BITS]];
    end
    return y;
  endfunction

  // Output position t takes the input bit at position map[t]; position 0 is the MSB.
  function automatic block_t permute(block_t x, pos_map_t map);
    block_t y;
    for (int t = 0; t < BLOCK_BITS; t++) begin
      y[BLOCK_BITS-1-t] = x[POS_W'(BLOCK_BITS - 1) - map[t]];
    end
    return y;
  endfunction

  function automatic sbox_t sbox_from(logic [TABLE_W-1:0] table_v);
    sbox_t s;
    for (int v = 0; v < SBOX_SIZE; v++) begin
      s[v] = table_v[TABLE_W-NIB_W*(v+1) +: GROUP_BITS];
    end
    return s;
  endfunction

  // The highest input with a matching entry wins; outputs never produced map to zero.
  function automatic sbox_t sbox_invert(sbox_t s);
    sbox_t inv;
    inv = '0;
    for (int v = 0; v < SBOX_SIZE; v++) begin
      inv[s[v]] = GROUP_BITS'(v);
    end
    return inv;
  endfunction

  function automatic logic [BLOCK_BITS-1:0] perm_hits(logic [TABLE_W-1:0] table_v);
    logic [BLOCK_BITS-1:0] hit;
    logic [NIB_W-1:0]      t;
    hit = '0;
    for (int p = 0; p < BLOCK_BITS; p++) begin
      t = table_v[TABLE_W-1-NIB_W*p -: NIB_W];
      if (int'(t) < BLOCK_BITS) begin
        hit[t[POS_W-1:0]] = 1'b1;
      end
    end
    return hit;
  endfunction

  // Source of each target position; later sources win, unused targets keep their bit.
  function automatic pos_map_t perm_fwd_map(logic [TABLE_W-1:0] table_v);
    pos_map_t         m;
    logic [NIB_W-1:0] t;
    for (int i = 0; i < BLOCK_BITS; i++) begin
      m[i] = POS_W'(i);
    end
    for (int p = 0; p < BLOCK_BITS; p++) begin
      t = table_v[TABLE_W-1-NIB_W*p -: NIB_W];
      if (int'(t) < BLOCK_BITS) begin
        m[t[POS_W-1:0]] = POS_W'(p);
      end
    end
    return m;
  endfunction

  function automatic pos_map_t perm_inv_map(logic [TABLE_W-1:0] table_v);
    pos_map_t              m;
    pos_map_t              fwd;
    logic [BLOCK_BITS-1:0] hit;
    fwd = perm_fwd_map(table_v);
    hit = perm_hits(table_v);
    for (int i = 0; i < BLOCK_BITS; i++) begin
      m[i] = POS_W'(i);
    end
    for (int q = 0; q < BLOCK_BITS; q++) begin
      if (hit[q]) begin
        m[fwd[q]] = POS_W'(q);
      end
    end
    return m;
  endfunction

endpackage

@@ rtl/spn_tables.sv @@
// Configuration registers of the cipher and the lookup tables derived from them.
// Inverse S-box and both permutation maps are built when a register is written.
// Depends on spn_pkg.
module spn_tables (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [spn_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [spn_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output spn_pkg::spn_tables_t                tables_o
);

  spn_pkg::spn_tables_t tables_d, tables_q;

  assign cfg_ready_o = 1'b1;
  assign tables_o    = tables_q;

  always_comb begin
    tables_d = tables_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        spn_pkg::CFG_ROUND_COUNT: begin
          tables_d.rounds = spn_pkg::clamp_rounds(cfg_data_i[spn_pkg::CNT_W-1:0]);
        end
        spn_pkg::CFG_CIPHER_KEY: begin
          tables_d.key = cfg_data_i[spn_pkg::KEY_BITS-1:0];
        end
        spn_pkg::CFG_SBOX_TABLE: begin
          tables_d.sbox     = spn_pkg::sbox_from(cfg_data_i[spn_pkg::TABLE_W-1:0]);
          tables_d.sbox_inv = spn_pkg::sbox_invert(
                                spn_pkg::sbox_from(cfg_data_i[spn_pkg::TABLE_W-1:0]));
        end
        spn_pkg::CFG_PERM_TABLE: begin
          tables_d.perm_fwd = spn_pkg::perm_fwd_map(cfg_data_i[spn_pkg::TABLE_W-1:0]);
          tables_d.perm_inv = spn_pkg::perm_inv_map(cfg_data_i[spn_pkg::TABLE_W-1:0]);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tables_q.rounds   <= spn_pkg::clamp_rounds(spn_pkg::CNT_W'(spn_pkg::ROUND_RST));
      tables_q.key      <= '0;
      tables_q.sbox     <= spn_pkg::sbox_from('0);
      tables_q.sbox_inv <= spn_pkg::sbox_invert(spn_pkg::sbox_from('0));
      tables_q.perm_fwd <= spn_pkg::perm_fwd_map('0);
      tables_q.perm_inv <= spn_pkg::perm_inv_map('0);
    end else begin
      tables_q <= tables_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_rounds_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tables_q.rounds != '0 && int'(tables_q.rounds) <= spn_pkg::MAX_ROUNDS)
    else $error("round count outside its range");

  a_sbox_inverse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tables_q.sbox[tables_q.sbox_inv[tables_q.sbox[0]]] == tables_q.sbox[0])
    else $error("inverse S-box does not undo the S-box");

  a_round_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_index_i == spn_pkg::CFG_ROUND_COUNT &&
     cfg_data_i[spn_pkg::CNT_W-1:0] == '0) |=> tables_q.rounds == spn_pkg::ROUND_W'(1))
    else $error("zero round count not taken as one");
`endif

endmodule

@@ rtl/spn_round.sv @@
// One pipeline stage of the cipher: a full round, the final round or a pass-through.
// The stage number and the direction select the round keys and the operations.
// Depends on spn_pkg.
module spn_round (
  input  spn_pkg::spn_tables_t          tables_i,
  input  logic [spn_pkg::ROUND_W-1:0]   stage_i,
  input  logic                          decrypt_i,
  input  spn_pkg::block_t               data_i,
  output spn_pkg::block_t               data_o
);

  logic [spn_pkg::ROUND_W-1:0] rounds;
  logic [spn_pkg::ROUND_W-1:0] key_hi_idx, key_lo_idx;
  spn_pkg::block_t             key_hi, key_lo;
  spn_pkg::block_t             sub_in, sub_out;
  spn_pkg::sbox_t              sbox_sel;

  assign rounds = tables_i.rounds;

  always_comb begin
    if (decrypt_i) begin
      key_hi_idx = rounds + spn_pkg::ROUND_W'(1);
      key_lo_idx = rounds - stage_i + spn_pkg::ROUND_W'(1);
      sbox_sel   = tables_i.sbox_inv;
    end else begin
      key_hi_idx = stage_i;
      key_lo_idx = stage_i + spn_pkg::ROUND_W'(1);
      sbox_sel   = tables_i.sbox;
    end
    key_hi = spn_pkg::round_key(tables_i.key, key_hi_idx);
    key_lo = spn_pkg::round_key(tables_i.key, key_lo_idx);

    if (decrypt_i && stage_i != spn_pkg::ROUND_W'(1)) begin
      sub_in = spn_pkg::permute(data_i, tables_i.perm_inv);
    end else begin
      sub_in = data_i ^ key_hi;
    end
    sub_out = spn_pkg::substitute(sub_in, sbox_sel);

    if (stage_i > rounds) begin
      data_o = data_i;
    end else if (!decrypt_i && stage_i < rounds) begin
      data_o = spn_pkg::permute(sub_out, tables_i.perm_fwd);
    end else begin
      data_o = sub_out ^ key_lo;
    end
  end

endmodule

@@ rtl/spn_block_cipher.sv @@
// Top level of the substitution-permutation network block cipher.
// Input register, one stage per round and the output register; depends on spn_pkg,
// spn_tables and spn_round.
//
// Usage:
// The slave stream carries the block in s_axis_tdata and the direction in
// s_axis_tuser (0 encrypt, 1 decrypt). The master stream returns one result
// block per transaction in m_axis_tdata, with bits above the block width at zero.
// The configuration channel writes round count, key, S-box and permutation tables
// by index; it is always ready, and the user must write it only while no block is
// in flight, as the block itself does not enforce this. A transaction enters the
// input register and then passes one register per possible round, whatever the
// round count, before the result is offered. One block is accepted every cycle
// while the output is not stalled. Reset empties the pipeline and loads the
// default configuration (four rounds, zero key and tables). When the receiver
// stalls with a result waiting, the whole pipeline holds and s_axis_tready drops
// in the same cycle; it rises again in the cycle the result is taken.
module spn_block_cipher (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [spn_pkg::DATA_W-1:0]        s_axis_tdata,   // data_block
  input  logic [0:0]                        s_axis_tuser,   // req_type
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [spn_pkg::DATA_W-1:0]        m_axis_tdata,   // result_block
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [spn_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [spn_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  spn_pkg::spn_tables_t              tables;
  logic                              advance;
  logic [spn_pkg::MAX_ROUNDS:0]      valid_q;
  logic [spn_pkg::MAX_ROUNDS:0]      mode_q;
  spn_pkg::block_t                   data_q    [0:spn_pkg::MAX_ROUNDS];
  spn_pkg::block_t                   stage_out [1:spn_pkg::MAX_ROUNDS];

  spn_tables u_tables (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .tables_o    (tables)
  );

  assign advance       = !valid_q[spn_pkg::MAX_ROUNDS] || m_axis_tready;
  assign s_axis_tready = advance;
  assign m_axis_tvalid = valid_q[spn_pkg::MAX_ROUNDS];
  assign m_axis_tdata  = spn_pkg::DATA_W'(data_q[spn_pkg::MAX_ROUNDS]);

  for (genvar k = 1; k <= spn_pkg::MAX_ROUNDS; k++) begin : g_stage
    spn_round u_round (
      .tables_i  (tables),
      .stage_i   (spn_pkg::ROUND_W'(k)),
      .decrypt_i (mode_q[k-1]),
      .data_i    (data_q[k-1]),
      .data_o    (stage_out[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (advance) begin
      valid_q <= {valid_q[spn_pkg::MAX_ROUNDS-1:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      mode_q    <= {mode_q[spn_pkg::MAX_ROUNDS-1:0], s_axis_tuser[0]};
      data_q[0] <= s_axis_tdata[spn_pkg::BLOCK_BITS-1:0];
      for (int k = 1; k <= spn_pkg::MAX_ROUNDS; k++) begin
        data_q[k] <= stage_out[k];
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> valid_q[0])
    else $error("accepted transaction missing from the input register");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[spn_pkg::MAX_ROUNDS] && !m_axis_tready) |=>
      ($stable(valid_q) && $stable(data_q[spn_pkg::MAX_ROUNDS])))
    else $error("pipeline moved during a stall");

  a_bubble_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !valid_q[0]) |=> !valid_q[1])
    else $error("empty stage produced a transaction");
`endif

endmodule

@@ tb/tb_spn_block_cipher.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for spn_block_cipher: directed table, then random phases.
// Expected blocks come from the known results in the directed table, else from a behavioral model kept in this file.
// Depends on spn_pkg and the spn_block_cipher RTL.
module tb_spn_block_cipher;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;
  localparam int unsigned NUM_PHASES      = 14;
  localparam int unsigned ITEMS_PER_PHASE = 125;
  localparam int unsigned NUM_ROWS        = 40;

  typedef struct packed {
    bit                an_cfg;
    spn_pkg::cfg_reg_e idx;
    logic [63:0]       val;
    logic              op;
    spn_pkg::block_t   blk;
    bit                known;
    spn_pkg::block_t   res;
  } step_row_t;

  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [spn_pkg::DATA_W-1:0]     s_axis_tdata  = '0;
  logic [0:0]                     s_axis_tuser  = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [spn_pkg::DATA_W-1:0]     m_axis_tdata;
  logic                           cfg_valid_i   = 1'b0;
  logic                           cfg_ready_o;
  logic [spn_pkg::CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [spn_pkg::CFG_DATA_W-1:0] cfg_data_i    = '0;

  logic [3:0]  rounds_cfg = 4'd4;
  logic [47:0] key_cfg    = '0;
  logic [63:0] sbox_cfg   = '0;
  logic [63:0] perm_cfg   = '0;

  spn_pkg::block_t expected_blocks[$];
  int unsigned     mismatch_cnt = 0;
  int unsigned     tx_idle_pct  = 0;
  int unsigned     rx_stall_pct = 0;

  step_row_t directed_rows [NUM_ROWS] = '{
    '{1'b0, spn_pkg::CFG_ROUND_COUNT, 64'h0, OP_ENCRYPT, 16'h0000, 1'b1, 16'h0000},
    '{1'b0, spn_pkg::CFG_ROUND_COUNT, 64'h0, OP_ENCRYPT, 16'hFFFF, 1'b1, 16'h0000},
    '{1'b0, spn_pkg::CFG_ROUND_COUNT, 64'h0, OP_DECRYPT, 16'h0000, 1'b0, 16'h0000},
    '{1'b0, spn_pkg::CFG_ROUND_COUNT, 64'h0, OP_DECRYPT, 16'hFFFF, 1'b0, 16'h0000},
    '{1'b1, spn_pkg::CFG_SBOX_TABLE, 64'h0123456789ABCDEF, OP_ENCRYPT, 16'h0, 1'b0, 16'h0},
    '{1'b1, spn_pkg::CFG_PERM_TABLE, 64'h0123456789ABCDEF, OP_ENCRYPT, 16'h0, 1'b0, 16'h0},
    '{1'b0, spn_pkg::CFG_ROUND_COUNT, 64'h0, OP_ENCRYPT, 16'hA5C3, 1'b1, 16'hA5C3},
    '{1'b0, spn_pkg::CFG_ROUND_COUNT, 64'h0, OP_DECRYPT, 16'h5A3C, 1'b1, 16'h5A3C},
    '{1'b1, spn_pkg::CFG_CIPHER_KEY, 64'hFFFF_FFFF_FFFF, OP_ENCRYPT, 16'h0, 1'b0, 16'h0},
    '{1'b1, spn_pkg::CFG_ROUND_COUNT, 64'h0, OP_ENCRYPT, 16'h0, 1'b0, 16'h0},
    '{1'b0, spn_pkg::CFG_ROUND_COUNT, 64'h0, OP_ENCRYPT, 16'h0000, 1'b1, 16'h0000},
    '{1'b0, spn_pkg::CFG_ROUND_COUNT, 64'h0, OP_DECRYPT, 16'hFFFF, 1'b1, 16'hFFFF},
    '{1'b1, spn_pkg::CFG_ROUND_COUNT, 64'hF, OP_ENCRYPT, 16'h0, 1'b0, 16'h0},
    '{1'b0, spn_pkg::CFG_ROUND_COUNT, 64'h0, OP_ENCRYPT, 16'h0000, 1'b0, 16'h0000},
    '{1'b0, spn_pkg::CFG_ROUND_COUNT, 64'h0, OP_DECRYPT, 16'h8001, 1'b0, 16'h0000},
    '{1'b1, spn_pkg::CFG_ROUND_COUNT, 64'h8, OP_ENCRYPT, 16'h0, 1'b0, 16'h0},
    '{1'b1, spn_pkg::CFG_CIPHER_KEY, 64'h1234_5678_9ABC, OP_ENCRYPT, 16'h0, 1'b0, 16'h0},
    '{1'b1, spn_pkg::CFG_SBOX_TABLE, 64'hC56B90AD3EF84712, OP_ENCRYPT, 16'h0, 1'b0, 16'h0},
    '{1'b1, spn_pkg::CFG_PERM_TABLE, 64'h048C159D26AE37BF, OP_ENCRYPT, 16'h0, 1'b0, 16'h0},
    '{1'b0, spn_pkg::CFG_ROUND_COUNT, 64'h0, OP_ENCRYPT, 16'h0000, 1'b0, 16'h0000},
    '{1'b0, spn_pkg::CFG_ROUND_COUNT, 64'h0, OP_ENCRYPT, 16'hFFFF, 1'b0, 16'h0000},
    '{1'b0, spn_pkg::CFG_ROUND_COUNT, 64'h0, OP_DECRYPT, 16'h0000, 1'b0, 16'h0000},
    '{1'b0, spn_pkg::CFG_ROUND_COUNT, 64'h0, OP_DECRYPT, 16'hFFFF, 1'b0, 16'h0000},
    '{1'b0, spn_pkg::CFG_ROUND_COUNT, 64'h0, OP_ENCRYPT, 16'h8000, 1'b0, 16'h0000},
    '{1'b0, spn_pkg::CFG_ROUND_COUNT, 64'h0, OP_DECRYPT, 16'h0001, 1'b0, 16'h0000},
    '{1'b1, spn_pkg::CFG_ROUND_COUNT, 64'h1, OP_ENCRYPT, 16'h0, 1'b0, 16'h0},
    '{1'b0, spn_pkg::CFG_ROUND_COUNT, 64'h0, OP_ENCRYPT, 16'h1234, 1'b0, 16'h0000},
    '{1'b0, spn_pkg::CFG_ROUND_COUNT, 64'h0, OP_DECRYPT, 16'h1234, 1'b0, 16'h0000},
    '{1'b1, spn_pkg::CFG_SBOX_TABLE, 64'h0000111122223333, OP_ENCRYPT, 16'h0, 1'b0, 16'h0},
    '{1'b1, spn_pkg::CFG_PERM_TABLE, 64'hFFFF0000FFFF0000, OP_ENCRYPT, 16'h0, 1'b0, 16'h0},
    '{1'b1, spn_pkg::CFG_ROUND_COUNT, 64'h9, OP_ENCRYPT, 16'h0, 1'b0, 16'h0},
    '{1'b0, spn_pkg::CFG_ROUND_COUNT, 64'h0, OP_ENCRYPT, 16'hBEEF, 1'b0, 16'h0000},
    '{1'b0, spn_pkg::CFG_ROUND_COUNT, 64'h0, OP_DECRYPT, 16'hBEEF, 1'b0, 16'h0000},
    '{1'b0, spn_pkg::CFG_ROUND_COUNT, 64'h0, OP_DECRYPT, 16'h0F0F, 1'b0, 16'h0000},
    '{1'b1, spn_pkg::CFG_ROUND_COUNT, 64'hFFFFFFFFFFFFFFF4, OP_ENCRYPT, 16'h0, 1'b0, 16'h0},
    '{1'b0, spn_pkg::CFG_ROUND_COUNT, 64'h0, OP_ENCRYPT, 16'h7E81, 1'b0, 16'h0000},
    '{1'b0, spn_pkg::CFG_ROUND_COUNT, 64'h0, OP_DECRYPT, 16'h7E81, 1'b0, 16'h0000},
    '{1'b1, spn_pkg::CFG_CIPHER_KEY, 64'hDEAD000000000001, OP_ENCRYPT, 16'h0, 1'b0, 16'h0},
    '{1'b0, spn_pkg::CFG_ROUND_COUNT, 64'h0, OP_ENCRYPT, 16'hC3C3, 1'b0, 16'h0000},
    '{1'b0, spn_pkg::CFG_ROUND_COUNT, 64'h0, OP_DECRYPT, 16'h3C3C, 1'b0, 16'h0000}
  };

  spn_block_cipher DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic [3:0] table_nibble(logic [63:0] tbl, int unsigned idx);
    return tbl[63 - 4 * idx -: 4];
  endfunction

  function automatic spn_pkg::block_t key_window(int unsigned i);
    logic [47:0] sh;
    sh = key_cfg >> (spn_pkg::KEY_BITS - (i - 1 + spn_pkg::GROUPS) * spn_pkg::GROUP_BITS);
    return sh[15:0];
  endfunction

  // The highest input whose entry matches wins; no match gives zero.
  function automatic logic [3:0] sbox_preimage(logic [3:0] y);
    logic [3:0] found;
    found = '0;
    for (int v = 0; v < 16; v++) begin
      if (table_nibble(sbox_cfg, v) == y) begin
        found = 4'(v);
      end
    end
    return found;
  endfunction

  function automatic spn_pkg::block_t sub_layer(spn_pkg::block_t x, bit inverse);
    spn_pkg::block_t y;
    logic [3:0]      v;
    y = '0;
    for (int g = 0; g < 4; g++) begin
      v = x[(3 - g) * 4 +: 4];
      y[(3 - g) * 4 +: 4] = inverse ? sbox_preimage(v) : table_nibble(sbox_cfg, v);
    end
    return y;
  endfunction

  function automatic spn_pkg::block_t bit_shuffle(spn_pkg::block_t x);
    spn_pkg::block_t y;
    int unsigned     t;
    y = x;
    for (int p = 0; p < 16; p++) begin
      t = table_nibble(perm_cfg, p);
      y[15 - t] = x[15 - p];
    end
    return y;
  endfunction

  function automatic spn_pkg::block_t bit_unshuffle(spn_pkg::block_t x);
    spn_pkg::block_t y;
    bit              hit;
    int unsigned     src;
    y = x;
    for (int q = 0; q < 16; q++) begin
      hit = 1'b0;
      src = 0;
      for (int p = 0; p < 16; p++) begin
        if (table_nibble(perm_cfg, p) == q) begin
          hit = 1'b1;
          src = p;
        end
      end
      if (hit) begin
        y[15 - src] = x[15 - q];
      end
    end
    return y;
  endfunction

  function automatic spn_pkg::block_t cipher_expected(logic op, spn_pkg::block_t blk);
    spn_pkg::block_t x;
    int              r;
    x = blk;
    r = int'(rounds_cfg);
    if (r < 1) begin
      r = 1;
    end
    if (r > spn_pkg::MAX_ROUNDS) begin
      r = spn_pkg::MAX_ROUNDS;
    end
    if (op == OP_ENCRYPT) begin
      for (int i = 1; i < r; i++) begin
        x = bit_shuffle(sub_layer(x ^ key_window(i), 1'b0));
      end
      x = sub_layer(x ^ key_window(r), 1'b0) ^ key_window(r + 1);
    end else begin
      x = sub_layer(x ^ key_window(r + 1), 1'b1) ^ key_window(r);
      for (int i = r - 1; i >= 1; i--) begin
        x = sub_layer(bit_unshuffle(x), 1'b1) ^ key_window(i);
      end
    end
    return x;
  endfunction

  function automatic logic [63:0] shuffled_table();
    logic [3:0]  v [16];
    logic [3:0]  t;
    logic [63:0] r;
    int unsigned j;
    for (int i = 0; i < 16; i++) begin
      v[i] = 4'(i);
    end
    for (int i = 15; i > 0; i--) begin
      j = $urandom_range(i);
      t = v[i];
      v[i] = v[j];
      v[j] = t;
    end
    for (int i = 0; i < 16; i++) begin
      r[63 - 4 * i -: 4] = v[i];
    end
    return r;
  endfunction

  task automatic note_error(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("%0t ns: %s", $time, msg);
    end
  endtask

  always @(posedge clk_i) begin
    spn_pkg::block_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_blocks.size() == 0) begin
        note_error($sformatf("result %h arrived with none expected", m_axis_tdata));
      end else begin
        want = expected_blocks.pop_front();
        if (m_axis_tdata !== want) begin
          note_error($sformatf("result_block expected %h, got %h", want, m_axis_tdata));
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  task automatic send_block(input logic op, input spn_pkg::block_t blk, input bit known,
                            input spn_pkg::block_t res);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= blk;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_blocks.push_back(known ? res : cipher_expected(op, blk));
  endtask

  task automatic stream_drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_blocks.size() != 0);
  endtask

  task automatic write_reg(input spn_pkg::cfg_reg_e idx, input logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      spn_pkg::CFG_ROUND_COUNT: rounds_cfg = val[3:0];
      spn_pkg::CFG_CIPHER_KEY:  key_cfg    = val[47:0];
      spn_pkg::CFG_SBOX_TABLE:  sbox_cfg   = val;
      spn_pkg::CFG_PERM_TABLE:  perm_cfg   = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  initial begin
    logic [63:0]     val;
    logic [3:0]      rc;
    logic            op;
    spn_pkg::block_t blk;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[k]) begin
      if (directed_rows[k].an_cfg) begin
        stream_drain();
        write_reg(directed_rows[k].idx, directed_rows[k].val);
      end else begin
        send_block(directed_rows[k].op, directed_rows[k].blk, directed_rows[k].known,
                   directed_rows[k].res);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      stream_drain();
      case ($urandom_range(5))
        0: rc = 4'd0;
        1: rc = 4'd1;
        2: rc = 4'd8;
        3: rc = 4'd15;
        default: rc = 4'($urandom_range(15));
      endcase
      val = {$urandom(), $urandom()};
      if ($urandom_range(3) != 0) begin
        val[63:4] = '0;
      end
      val[3:0] = rc;
      write_reg(spn_pkg::CFG_ROUND_COUNT, val);
      val = {$urandom(), $urandom()};
      case ($urandom_range(7))
        0: val = '0;
        1: val = '1;
        2: ;
        default: val[63:48] = '0;
      endcase
      write_reg(spn_pkg::CFG_CIPHER_KEY, val);
      write_reg(spn_pkg::CFG_SBOX_TABLE, ($urandom_range(4) != 0) ? shuffled_table() :
                                         {$urandom(), $urandom()});
      write_reg(spn_pkg::CFG_PERM_TABLE, ($urandom_range(4) != 0) ? shuffled_table() :
                                         {$urandom(), $urandom()});
      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 50; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 50; end
        default: begin tx_idle_pct = 12; rx_stall_pct = 12; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 5 && n == ITEMS_PER_PHASE / 2) begin
          stream_drain();
        end
        op  = 1'($urandom_range(1));
        blk = 16'($urandom());
        case ($urandom_range(15))
          0: blk = '0;
          1: blk = '1;
          default: ;
        endcase
        send_block(op, blk, 1'b0, '0);
      end
    end

    stream_drain();
    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("** spn_block_cipher: PASSED **");
    end else begin
      $display("** spn_block_cipher: FAILED **");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("** spn_block_cipher: FAILED **");
    $finish;
  end

endmodule
